### rtl/core/vfd_pkg.sv
// shared types, constants and lookup tables for the video format detector
package vfd_pkg;

    localparam int unsigned ClkNumer   = 124 * 255 / 10;
    localparam logic [7:0]  NoCode     = 8'hff;
    localparam logic [5:0]  Rate60     = 6'd60;
    localparam logic [5:0]  Rate50     = 6'd50;
    localparam logic [5:0]  Rate30     = 6'd30;
    localparam logic [5:0]  Rate0      = 6'd0;
    localparam logic [19:0] RateScale  = 20'd1000000;

    typedef struct packed {
        logic        video_on;
        logic [7:0]  video_code;
        logic [13:0] h_total;
        logic [13:0] h_active;
        logic [11:0] v_total;
        logic [11:0] v_active;
        logic [7:0]  clock_count;
    } in_t;

    typedef struct packed {
        logic        format_valid;
        logic [13:0] width;
        logic [11:0] height;
        logic [5:0]  frame_rate;
        logic [7:0]  code_out;
    } out_t;

    // rate comparison flags handed from the arithmetic pipe to the output stage
    typedef struct packed {
        logic above_55;
        logic above_45;
        logic above_25;
        logic zero_total;
    } rate_flags_t;

    typedef struct packed {
        logic        hit;
        logic [13:0] width;
        logic [11:0] height;
        logic [5:0]  rate;
    } fmt_t;

    typedef logic [11:0] pclk_table_t [256];

    // pixel clock in MHz per count byte, nested truncation folds into one quotient
    // quotient built by repeated subtraction at elaboration, zero count gives zero
    function automatic pclk_table_t build_pclk_table();
        pclk_table_t t;
        int unsigned rem;
        int unsigned q;
        for (int unsigned i = 0; i < 256; i++)
        begin
            rem = ClkNumer;
            q   = 0;
            if (i != 0)
            begin
                while (rem >= i)
                begin
                    rem = rem - i;
                    q   = q + 1;
                end
            end
            t[i] = 12'(q);
        end
        return t;
    endfunction

    localparam pclk_table_t PclkTable = build_pclk_table();

    function automatic fmt_t fmt_lookup(input logic [7:0] code);
        fmt_t f;
        f = '{hit: 1'b1, width: 14'd0, height: 12'd0, rate: Rate0};
        case (code)
            8'd2:    f = '{1'b1, 14'd720,  12'd480,  Rate50};
            8'd3:    f = '{1'b1, 14'd720,  12'd480,  Rate60};
            8'd17:   f = '{1'b1, 14'd720,  12'd576,  Rate50};
            8'd18:   f = '{1'b1, 14'd720,  12'd576,  Rate60};
            8'd4:    f = '{1'b1, 14'd1280, 12'd720,  Rate60};
            8'd19:   f = '{1'b1, 14'd1280, 12'd720,  Rate50};
            8'd34:   f = '{1'b1, 14'd1920, 12'd1080, Rate30};
            default: f = '{1'b0, 14'd0,    12'd0,    Rate0};
        endcase
        return f;
    endfunction

endpackage

### rtl/core/vfd_rate_pipe.sv
// two-stage frame rate arithmetic: pixel clock and frame size, then threshold compares
module vfd_rate_pipe (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 valid,
    input  vfd_pkg::in_t         data,
    output logic                 valid_o,
    output vfd_pkg::in_t         data_o,
    output vfd_pkg::rate_flags_t flags
);
    import vfd_pkg::*;

    logic        s1_valid_reg;
    in_t         s1_data_reg;
    logic [11:0] s1_pclk_reg;
    logic [25:0] s1_area_reg;
    logic        s2_valid_reg;
    in_t         s2_data_reg;
    rate_flags_t s2_flags_reg;

    logic [31:0] scaled;
    logic [31:0] lim_55;
    logic [31:0] lim_45;
    logic [31:0] lim_25;
    rate_flags_t flags_next;

    always_comb
    begin
        scaled = 32'(s1_pclk_reg) * 32'(RateScale);
        // rate > n  is  pclk*1e6 >= (n+1)*h*v
        lim_55 = 32'(s1_area_reg) * 32'd56;
        lim_45 = 32'(s1_area_reg) * 32'd46;
        lim_25 = 32'(s1_area_reg) * 32'd26;
        flags_next.above_55   = scaled >= lim_55;
        flags_next.above_45   = scaled >= lim_45;
        flags_next.above_25   = scaled >= lim_25;
        flags_next.zero_total = s1_area_reg == 26'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_data_reg  <= data;
            s1_pclk_reg  <= PclkTable[data.clock_count];
            s1_area_reg  <= 26'(data.h_total) * 26'(data.v_total);
            s2_data_reg  <= s1_data_reg;
            s2_flags_reg <= flags_next;
        end
    end

    assign valid_o = s2_valid_reg;
    assign data_o  = s2_data_reg;
    assign flags   = s2_flags_reg;

endmodule

### rtl/core/video_format_detector_top.sv
// video format detector top level: rate pipe plus classification and output register
//
//  channel | signals                    | payload
//  src     | src_valid, src_stall       | src_data (vfd_pkg::in_t)
//  res     | res_valid, res_stall       | res_data (vfd_pkg::out_t)
//
// three register stages, one item per cycle unless a stalled result freezes the pipe
// the depth is set by the table lookup and h*v multiply, the 1e6 scaling
// and compares, and the format classification
// reset clears the stage valid bits only
// a stalled result freezes the whole pipe and src_stall follows it
module video_format_detector_top (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          src_valid,
    output logic          src_stall,
    input  vfd_pkg::in_t  src_data,
    output logic          res_valid,
    input  logic          res_stall,
    output vfd_pkg::out_t res_data
);
    import vfd_pkg::*;

    logic        en;
    logic        p_valid;
    in_t         p_data;
    rate_flags_t p_flags;
    fmt_t        fmt;
    out_t        res_next;
    logic [5:0]  est_rate;
    logic        out_valid_reg;
    out_t        out_data_reg;

    assign en        = !(out_valid_reg && res_stall);
    assign src_stall = !en;

    vfd_rate_pipe u_rate (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .valid   (src_valid),
        .data    (src_data),
        .valid_o (p_valid),
        .data_o  (p_data),
        .flags   (p_flags)
    );

    always_comb
    begin
        fmt = fmt_lookup(p_data.video_code);
        if (p_flags.zero_total)
        begin
            est_rate = Rate0;
        end
        else if (p_flags.above_55)
        begin
            est_rate = Rate60;
        end
        else if (p_flags.above_45)
        begin
            est_rate = Rate50;
        end
        else if (p_flags.above_25)
        begin
            est_rate = Rate30;
        end
        else
        begin
            est_rate = Rate0;
        end

        if (!p_data.video_on)
        begin
            res_next = '{1'b0, 14'd0, 12'd0, Rate0, NoCode};
        end
        else if (fmt.hit)
        begin
            res_next = '{1'b1, fmt.width, fmt.height, fmt.rate, p_data.video_code};
        end
        else
        begin
            res_next = '{1'b1, p_data.h_active, p_data.v_active, est_rate, NoCode};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= p_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= res_next;
        end
    end

    assign res_valid = out_valid_reg;
    assign res_data  = out_data_reg;

`ifndef ASSERT_OFF
    a_stall_follows_output: assert property (@(posedge clk) disable iff (!rst_n)
        src_stall == (res_valid && res_stall))
        else $error("input stall does not track output backpressure");

    a_rate_legal: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_data.frame_rate == Rate0 || res_data.frame_rate == Rate30 ||
                       res_data.frame_rate == Rate50 || res_data.frame_rate == Rate60))
        else $error("frame rate outside the known set");

    a_off_result: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_data.format_valid) |->
            (res_data.code_out == NoCode && res_data.width == 14'd0 &&
             res_data.height == 12'd0))
        else $error("video off result not cleared");

    a_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_stall) |=> (res_valid && $stable(res_data)))
        else $error("stalled result changed");
`endif

endmodule

### tb/tb.sv
// testbench for the video format detector: random and directed timing snapshots
module tb;
    import vfd_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic src_valid = 1'b0;
    logic src_stall;
    in_t src_data = '0;
    logic res_valid;
    logic res_stall = 1'b0;
    out_t res_data;

    int hold_off = 0;
    bit hold_started = 1'b0;
    bit feeding_done = 1'b0;
    int n_sent = 0;
    int n_recv = 0;
    int n_known = 0;
    int n_est = 0;

    always #5 clk = ~clk;

    video_format_detector_top i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .src_valid(src_valid),
        .src_stall(src_stall),
        .src_data(src_data),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .res_data(res_data)
    );

    class format_scoreboard;
        out_t pending[$];
        int errors = 0;

        function out_t predict_format(in_t s);
            out_t r;
            longint unsigned pclk;
            longint unsigned rate;
            r.format_valid = 1'b1;
            r.code_out = s.video_code;
            if (!s.video_on)
            begin
                r = '0;
                r.code_out = 8'hff;
                return r;
            end
            case (s.video_code)
                8'd2: begin r.width = 14'd720; r.height = 12'd480; r.frame_rate = 6'd50; end
                8'd3: begin r.width = 14'd720; r.height = 12'd480; r.frame_rate = 6'd60; end
                8'd17: begin r.width = 14'd720; r.height = 12'd576; r.frame_rate = 6'd50; end
                8'd18: begin r.width = 14'd720; r.height = 12'd576; r.frame_rate = 6'd60; end
                8'd4: begin r.width = 14'd1280; r.height = 12'd720; r.frame_rate = 6'd60; end
                8'd19: begin r.width = 14'd1280; r.height = 12'd720; r.frame_rate = 6'd50; end
                8'd34: begin r.width = 14'd1920; r.height = 12'd1080; r.frame_rate = 6'd30; end
                default:
                begin
                    r.width = s.h_active;
                    r.height = s.v_active;
                    r.code_out = 8'hff;
                    rate = 0;
                    if (s.clock_count != 0 && s.h_total != 0 && s.v_total != 0)
                    begin
                        pclk = (longint'(124 * 255) / s.clock_count) / 10;
                        rate = pclk * 1000000 / s.h_total / s.v_total;
                    end
                    if (rate > 55) r.frame_rate = 6'd60;
                    else if (rate > 45) r.frame_rate = 6'd50;
                    else if (rate > 25) r.frame_rate = 6'd30;
                    else r.frame_rate = 6'd0;
                end
            endcase
            return r;
        endfunction

        function void note_input(in_t s);
            pending.push_back(predict_format(s));
        endfunction

        function void check_result(out_t got);
            out_t exp_r;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10) $display("unexpected result %p", got);
                return;
            end
            exp_r = pending.pop_front();
            if (got !== exp_r)
            begin
                errors++;
                if (errors <= 10) $display("mismatch: expected %p, got %p", exp_r, got);
            end
        endfunction
    endclass

    format_scoreboard sb = new();

    function int pick_gap();
        if ($urandom_range(0, 3) == 0) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        return $urandom_range(0, 3);
    endfunction

    task automatic send_snapshot(in_t s);
        int gap;
        gap = pick_gap();
        if (n_sent < 60 || n_sent > 400) gap = 0;
        repeat (gap)
        begin
            src_valid <= 1'b0;
            @(negedge clk);
        end
        src_valid <= 1'b1;
        src_data <= s;
        @(posedge clk);
        while (src_stall) @(posedge clk);
        sb.note_input(s);
        n_sent++;
        if (s.video_on && s.video_code inside {2, 3, 4, 17, 18, 19, 34}) n_known++;
        else if (s.video_on) n_est++;
        @(negedge clk);
    endtask

    // timing aimed at a random frame rate from 20 to 65, spanning the rate thresholds
    function in_t near_rate_snapshot();
        in_t s;
        int target;
        longint unsigned pclk;
        s = in_t'({$urandom, $urandom, $urandom});
        s.video_on = 1'b1;
        s.video_code = 8'($urandom_range(35, 254));
        s.clock_count = 8'($urandom_range(20, 255));
        pclk = (longint'(124 * 255) / s.clock_count) / 10;
        target = $urandom_range(20, 65);
        s.v_total = 12'($urandom_range(200, 1200));
        s.h_total = 14'((pclk * 1000000 / target) / s.v_total + $urandom_range(0, 2));
        if (s.h_total == 14'd0) s.h_total = 14'd1;
        return s;
    endfunction

    task automatic run_directed();
        in_t s;
        int codes[7] = '{2, 3, 4, 17, 18, 19, 34};
        s = '0;
        send_snapshot(s);
        s = '1;
        s.video_on = 1'b0;
        send_snapshot(s);
        foreach (codes[i])
        begin
            s = in_t'({$urandom, $urandom, $urandom});
            s.video_on = 1'b1;
            s.video_code = 8'(codes[i]);
            send_snapshot(s);
        end
        s = '1;
        send_snapshot(s);
        s = '1;
        s.clock_count = 8'd0;
        send_snapshot(s);
        s = '1;
        s.h_total = 14'd0;
        send_snapshot(s);
        s = '1;
        s.v_total = 12'd0;
        send_snapshot(s);
        s = '0;
        s.video_on = 1'b1;
        s.video_code = 8'd0;
        s.clock_count = 8'd1;
        s.h_total = 14'd1;
        s.v_total = 12'd1;
        send_snapshot(s);
        // 720p-like timing with unknown code: count 43 gives pclk 73, about 58 frames/s
        s.clock_count = 8'd43;
        s.h_total = 14'd1650;
        s.v_total = 12'd750;
        s.h_active = 14'd1280;
        s.v_active = 12'd720;
        send_snapshot(s);
        repeat (4) send_snapshot(near_rate_snapshot());
    endtask

    initial
    begin
        in_t s;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        run_directed();
        repeat (630)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: s = near_rate_snapshot();
                4:
                begin
                    s = in_t'({$urandom, $urandom, $urandom});
                    s.video_code = 8'($urandom_range(2, 34));
                end
                default: s = in_t'({$urandom, $urandom, $urandom});
            endcase
            send_snapshot(s);
        end
        src_valid <= 1'b0;
        feeding_done = 1'b1;
    end

    // long receiver hold-off while the sender keeps offering transfers
    always @(negedge clk)
    begin
        if (hold_off > 0)
        begin
            res_stall <= 1'b1;
            hold_off <= hold_off - 1;
        end
        else if (!hold_started && n_sent >= 100)
        begin
            hold_started <= 1'b1;
            hold_off <= 60;
            res_stall <= 1'b1;
        end
        else if (n_sent > 250 && n_sent < 400)
            res_stall <= 1'b0;
        else
            res_stall <= ($urandom_range(0, 3) == 0) || ($urandom_range(0, 49) == 0 && 1'b1);
    end

    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            sb.check_result(res_data);
            n_recv++;
        end
    end

    initial
    begin
        wait (feeding_done);
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        $display("covered %0d snapshots: %0d table formats, %0d estimated rates",
                 n_sent, n_known, n_est);
        $display("%0d results checked, %0d mismatches", n_recv, sb.errors);
        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end
endmodule
